>>> hw/rtl/pwsm_pkg.sv
// Shared types, constants and command/status structs of the pulse window speed meter.
`timescale 1ns / 1ps

package pwsm_pkg;

   // Item command codes.
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_PULSE = 2'd0;
   localparam cmd_type CMD_TICK  = 2'd1;
   localparam cmd_type CMD_CALC  = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_PULSE_LIMIT     = 2'd0;
   localparam csr_idx_type CSR_TIME_LIMIT      = 2'd1;
   localparam csr_idx_type CSR_STALE_TICKS     = 2'd2;
   localparam csr_idx_type CSR_DISTANCE_FACTOR = 2'd3;

   // Register reset values.
   localparam logic [9:0]  PULSE_LIMIT_RST     = 10'd500;
   localparam logic [31:0] TIME_LIMIT_RST      = 32'd1000000;
   localparam logic [15:0] STALE_TICKS_RST     = 16'd200;
   localparam logic [19:0] DISTANCE_FACTOR_RST = 20'd62172;

   // Arithmetic limits.
   localparam logic [31:0] MIN_TIME   = 32'd2;
   localparam logic [9:0]  MIN_PULSES = 10'd5;
   localparam logic [15:0] SPEED_MAX  = 16'hFFFF;

   // Iterative divider: one quotient bit per cycle.
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // Controller to datapath commands.
   typedef struct packed {
      logic do_pulse;
      logic do_tick;
      logic calc_prep;
      logic div_start_speed;
      logic speed_zero;
      logic div_step;
      logic speed_finish;
      logic div_start_mean;
      logic mean_finish;
      logic load_out;
   } dp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic short_time;
      logic many_pulses;
      logic div_last;
   } dp_status_type;

endpackage

>>> hw/rtl/pwsm_req_if.sv
// Input item channel: command and captured pulse period.
`timescale 1ns / 1ps

interface pwsm_req_if;
   logic              valid;
   logic              ready;
   pwsm_pkg::cmd_type cmd;
   logic [31:0]       period;

   modport source (output valid, output cmd, output period, input ready);
   modport sink (input valid, input cmd, input period, output ready);
endinterface

>>> hw/rtl/pwsm_rsp_if.sv
// Result item channel: speed, period change, pulse counts and window time.
`timescale 1ns / 1ps

interface pwsm_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        speed;
   logic signed [31:0] period_change;
   logic [31:0]        total_pulses;
   logic [9:0]         window_pulses;
   logic [31:0]        window_time;

   modport source (output valid, output speed, output period_change, output total_pulses,
                   output window_pulses, output window_time, input ready);
   modport sink (input valid, input speed, input period_change, input total_pulses,
                 input window_pulses, input window_time, output ready);
endinterface

>>> hw/rtl/pwsm_csr_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface pwsm_csr_if;
   logic                                valid;
   logic                                ready;
   pwsm_pkg::csr_idx_type               index;
   logic [pwsm_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/pwsm_datapath.sv
// Datapath: configuration, accumulators, window latch, multiplier, divider, result register.
`timescale 1ns / 1ps

module pwsm_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  pwsm_pkg::csr_idx_type           csr_index,
   input  logic [pwsm_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic [31:0]                     req_period,
   input  pwsm_pkg::dp_cmd_type            cmd,
   output pwsm_pkg::dp_status_type         status,
   output logic [15:0]                     rsp_speed,
   output logic signed [31:0]              rsp_period_change,
   output logic [31:0]                     rsp_total_pulses,
   output logic [9:0]                      rsp_window_pulses,
   output logic [31:0]                     rsp_window_time
);

   // Configuration.
   logic [9:0]  pulse_limit_ff, pulse_limit_in;
   logic [31:0] time_limit_ff, time_limit_in;
   logic [15:0] stale_ticks_ff, stale_ticks_in;
   logic [19:0] distance_factor_ff, distance_factor_in;

   // Measurement state.
   logic [31:0] time_accum_ff, time_accum_in;
   logic [9:0]  pulse_accum_ff, pulse_accum_in;
   logic [31:0] pulse_total_ff, pulse_total_in;
   logic [9:0]  latched_pulses_ff, latched_pulses_in;
   logic [31:0] latched_time_ff, latched_time_in;
   logic        window_ready_ff, window_ready_in;
   logic [31:0] tick_now_ff, tick_now_in;
   logic [31:0] stamp_tick_ff, stamp_tick_in;
   logic [31:0] prior_mean_ff, prior_mean_in;
   logic [15:0] speed_ff, speed_in;
   logic [31:0] change_ff, change_in;
   logic [9:0]  used_pulses_ff, used_pulses_in;
   logic [31:0] used_time_ff, used_time_in;

   // Divider.
   logic [31:0]                        quo_ff, quo_in;
   logic [31:0]                        rem_ff, rem_in;
   logic [31:0]                        dvsr_ff, dvsr_in;
   logic [pwsm_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;

   // Result register payload.
   logic [15:0] out_speed_ff, out_speed_in;
   logic [31:0] out_change_ff, out_change_in;
   logic [31:0] out_total_ff, out_total_in;
   logic [9:0]  out_wpulses_ff, out_wpulses_in;
   logic [31:0] out_wtime_ff, out_wtime_in;

   // Combinational helpers.
   logic [31:0] time_sum;
   logic [9:0]  pulse_next;
   logic        window_close;
   logic [31:0] stamp_next;
   logic [31:0] age;
   logic        stale;
   logic [29:0] product;
   logic [32:0] rem_shift;
   logic [32:0] rem_diff;
   logic        round_up;
   logic [32:0] quo_round;

   always_comb begin
      time_sum     = time_accum_ff + req_period;
      pulse_next   = pulse_accum_ff + 10'd1;
      window_close = (pulse_next == pulse_limit_ff) || (time_sum > time_limit_ff);
      stamp_next   = window_ready_ff ? tick_now_ff : stamp_tick_ff;
      age          = tick_now_ff - stamp_next;
      stale        = age > {16'd0, stale_ticks_ff};
      product      = used_pulses_ff * distance_factor_ff;
      rem_shift    = {rem_ff, quo_ff[31]};
      rem_diff     = rem_shift - {1'b0, dvsr_ff};
      round_up     = {rem_ff, 1'b0} >= {1'b0, dvsr_ff};
      quo_round    = {1'b0, quo_ff} + {32'd0, round_up};
   end

   always_comb begin
      pulse_limit_in     = pulse_limit_ff;
      time_limit_in      = time_limit_ff;
      stale_ticks_in     = stale_ticks_ff;
      distance_factor_in = distance_factor_ff;
      time_accum_in      = time_accum_ff;
      pulse_accum_in     = pulse_accum_ff;
      pulse_total_in     = pulse_total_ff;
      latched_pulses_in  = latched_pulses_ff;
      latched_time_in    = latched_time_ff;
      window_ready_in    = window_ready_ff;
      tick_now_in        = tick_now_ff;
      stamp_tick_in      = stamp_tick_ff;
      prior_mean_in      = prior_mean_ff;
      speed_in           = speed_ff;
      change_in          = change_ff;
      used_pulses_in     = used_pulses_ff;
      used_time_in       = used_time_ff;
      quo_in             = quo_ff;
      rem_in             = rem_ff;
      dvsr_in            = dvsr_ff;
      cnt_in             = cnt_ff;
      out_speed_in       = out_speed_ff;
      out_change_in      = out_change_ff;
      out_total_in       = out_total_ff;
      out_wpulses_in     = out_wpulses_ff;
      out_wtime_in       = out_wtime_ff;

      if (csr_write) begin
         case (csr_index)
            pwsm_pkg::CSR_PULSE_LIMIT:     pulse_limit_in     = csr_data[9:0];
            pwsm_pkg::CSR_TIME_LIMIT:      time_limit_in      = csr_data[31:0];
            pwsm_pkg::CSR_STALE_TICKS:     stale_ticks_in     = csr_data[15:0];
            pwsm_pkg::CSR_DISTANCE_FACTOR: distance_factor_in = csr_data[19:0];
            default: begin
            end
         endcase
      end

      if (cmd.do_pulse) begin
         pulse_total_in = pulse_total_ff + 32'd1;
         if (window_close) begin
            latched_time_in   = time_sum;
            latched_pulses_in = pulse_next;
            time_accum_in     = '0;
            pulse_accum_in    = '0;
            window_ready_in   = 1'b1;
         end else begin
            time_accum_in  = time_sum;
            pulse_accum_in = pulse_next;
         end
      end

      if (cmd.do_tick) begin
         tick_now_in = tick_now_ff + 32'd1;
      end

      // Take up a fresh window, then zero the counts if the stamp is too old.
      if (cmd.calc_prep) begin
         window_ready_in = 1'b0;
         stamp_tick_in   = stamp_next;
         used_pulses_in  = stale ? 10'd0 : latched_pulses_ff;
         used_time_in    = stale ? 32'd0 : latched_time_ff;
      end

      // The product never exceeds 30 bits, so it goes straight into the divider.
      if (cmd.div_start_speed) begin
         quo_in  = {2'd0, product};
         rem_in  = '0;
         dvsr_in = used_time_ff;
         cnt_in  = '0;
      end

      if (cmd.speed_zero) begin
         speed_in = '0;
      end

      if (cmd.div_step) begin
         if (!rem_diff[32]) begin
            rem_in = rem_diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_shift[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.speed_finish) begin
         speed_in = (|quo_round[32:16]) ? pwsm_pkg::SPEED_MAX : quo_round[15:0];
      end

      if (cmd.div_start_mean) begin
         quo_in  = used_time_ff;
         rem_in  = '0;
         dvsr_in = {22'd0, used_pulses_ff};
         cnt_in  = '0;
      end

      if (cmd.mean_finish) begin
         if (prior_mean_ff != 32'd0) begin
            change_in = quo_ff - prior_mean_ff;
         end
         prior_mean_in = quo_ff;
      end

      if (cmd.load_out) begin
         out_speed_in   = speed_ff;
         out_change_in  = change_ff;
         out_total_in   = pulse_total_ff;
         out_wpulses_in = used_pulses_ff;
         out_wtime_in   = used_time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_limit_ff     <= pwsm_pkg::PULSE_LIMIT_RST;
         time_limit_ff      <= pwsm_pkg::TIME_LIMIT_RST;
         stale_ticks_ff     <= pwsm_pkg::STALE_TICKS_RST;
         distance_factor_ff <= pwsm_pkg::DISTANCE_FACTOR_RST;
         time_accum_ff      <= '0;
         pulse_accum_ff     <= '0;
         pulse_total_ff     <= '0;
         latched_pulses_ff  <= '0;
         latched_time_ff    <= '0;
         window_ready_ff    <= 1'b0;
         tick_now_ff        <= '0;
         stamp_tick_ff      <= '0;
         prior_mean_ff      <= '0;
         speed_ff           <= '0;
         change_ff          <= '0;
         used_pulses_ff     <= '0;
         used_time_ff       <= '0;
      end else begin
         pulse_limit_ff     <= pulse_limit_in;
         time_limit_ff      <= time_limit_in;
         stale_ticks_ff     <= stale_ticks_in;
         distance_factor_ff <= distance_factor_in;
         time_accum_ff      <= time_accum_in;
         pulse_accum_ff     <= pulse_accum_in;
         pulse_total_ff     <= pulse_total_in;
         latched_pulses_ff  <= latched_pulses_in;
         latched_time_ff    <= latched_time_in;
         window_ready_ff    <= window_ready_in;
         tick_now_ff        <= tick_now_in;
         stamp_tick_ff      <= stamp_tick_in;
         prior_mean_ff      <= prior_mean_in;
         speed_ff           <= speed_in;
         change_ff          <= change_in;
         used_pulses_ff     <= used_pulses_in;
         used_time_ff       <= used_time_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      dvsr_ff        <= dvsr_in;
      cnt_ff         <= cnt_in;
      out_speed_ff   <= out_speed_in;
      out_change_ff  <= out_change_in;
      out_total_ff   <= out_total_in;
      out_wpulses_ff <= out_wpulses_in;
      out_wtime_ff   <= out_wtime_in;
   end

   assign status.short_time  = used_time_ff <= pwsm_pkg::MIN_TIME;
   assign status.many_pulses = used_pulses_ff > pwsm_pkg::MIN_PULSES;
   assign status.div_last    = cnt_ff == pwsm_pkg::DIV_LAST;

   assign rsp_speed         = out_speed_ff;
   assign rsp_period_change = signed'(out_change_ff);
   assign rsp_total_pulses  = out_total_ff;
   assign rsp_window_pulses = out_wpulses_ff;
   assign rsp_window_time   = out_wtime_ff;

endmodule

>>> hw/rtl/pwsm_ctrl.sv
// Controller: sequences each item through the datapath and owns both handshakes.
`timescale 1ns / 1ps

module pwsm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  pwsm_pkg::cmd_type       req_cmd,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pwsm_pkg::dp_cmd_type    cmd,
   input  pwsm_pkg::dp_status_type status
);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_PREP      = 8'b0000_0010,
      ST_MUL       = 8'b0000_0100,
      ST_DIV_SPEED = 8'b0000_1000,
      ST_FIN_SPEED = 8'b0001_0000,
      ST_DIV_MEAN  = 8'b0010_0000,
      ST_FIN_MEAN  = 8'b0100_0000,
      ST_LOAD      = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.do_pulse = req_cmd == pwsm_pkg::CMD_PULSE;
               cmd.do_tick  = req_cmd == pwsm_pkg::CMD_TICK;
               state_in     = (req_cmd == pwsm_pkg::CMD_CALC) ? ST_PREP : ST_LOAD;
            end
         end
         ST_PREP: begin
            cmd.calc_prep = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            if (status.short_time) begin
               cmd.speed_zero = 1'b1;
               state_in       = ST_LOAD;
            end else begin
               cmd.div_start_speed = 1'b1;
               state_in            = ST_DIV_SPEED;
            end
         end
         ST_DIV_SPEED: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIN_SPEED;
            end
         end
         ST_FIN_SPEED: begin
            cmd.speed_finish = 1'b1;
            if (status.many_pulses) begin
               cmd.div_start_mean = 1'b1;
               state_in           = ST_DIV_MEAN;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIN_MEAN;
            end
         end
         ST_FIN_MEAN: begin
            cmd.mean_finish = 1'b1;
            state_in        = ST_LOAD;
         end
         ST_LOAD: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   // A result is never written over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while occupied");

   // A calc transaction starts the calculation sequence.
   a_calc_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == pwsm_pkg::CMD_CALC) |=> state_ff == ST_PREP)
      else $error("calc transaction did not enter preparation");

   // Pulse, tick and unknown transactions go straight to the result load.
   a_simple_item: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd != pwsm_pkg::CMD_CALC) |=> state_ff == ST_LOAD)
      else $error("simple transaction did not go to result load");

   // The speed division ends after its last step.
   a_speed_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_SPEED && status.div_last) |=> state_ff == ST_FIN_SPEED)
      else $error("speed division did not finish");

   // Each completed load raises the result valid in the next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("result valid not raised after load");
`endif

endmodule

>>> hw/rtl/pulse_window_speed_meter.sv
// Top level of the pulse window speed meter: controller, datapath and channel ports.
`timescale 1ns / 1ps

// Pulse window speed meter. Each request transaction carries a command: a pulse adds its
// captured period to the window time sum and counts the pulse, latching the window when the
// pulse count reaches pulse_limit or the time sum exceeds time_limit; a tick advances the
// system tick counter; a calc takes up a freshly latched window, zeroes it if it is older
// than stale_ticks, and computes speed = pulses * distance_factor / time rounded half up and
// saturated at 65535 (0 when time is 2 or less), plus, when time is above 2, the change of
// mean pulse period when the window has more than 5 pulses. Every request transaction yields
// exactly one response transaction with the state after that command. One item is processed
// at a time: pulse, tick and unknown commands go from idle straight to the result load; a calc
// passes through preparation and the multiply state, then, unless time is short, the speed
// division and, with more than 5 pulses, the mean division, before the result load. The
// result load waits until the result register is free. The shared 32-step restoring divider
// is used once for the speed and once for the mean period. A result waits in an output
// register, so the next request is accepted while it is still pending; a new result loads
// only once the previous one has been taken. Configuration writes are always accepted and
// take effect at once; they are meant to be issued while no item is in flight.

module pulse_window_speed_meter (
   input  logic          clock,
   input  logic          reset,
   pwsm_req_if.sink      req,
   pwsm_rsp_if.source    rsp,
   pwsm_csr_if.sink      csr
);

   pwsm_pkg::dp_cmd_type    dp_cmd;
   pwsm_pkg::dp_status_type dp_status;

   // The configuration registers are plain flops, so a write never needs to wait.
   assign csr.ready = 1'b1;

   pwsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   pwsm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr.valid),
      .csr_index         (csr.index),
      .csr_data          (csr.data),
      .req_period        (req.period),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .rsp_speed         (rsp.speed),
      .rsp_period_change (rsp.period_change),
      .rsp_total_pulses  (rsp.total_pulses),
      .rsp_window_pulses (rsp.window_pulses),
      .rsp_window_time   (rsp.window_time)
   );

endmodule

>>> dv/pulse_window_speed_meter_tb.sv
// Self-checking testbench of the pulse window speed meter with a built-in predictor.
`timescale 1ns / 1ps

module pulse_window_speed_meter_tb;

   // Fourth command code, which the block ignores.
   localparam pwsm_pkg::cmd_type CMD_UNKNOWN = 2'd3;

   localparam int unsigned LIMIT_CYCLES  = 1000000;
   localparam int unsigned SETTLE_CYCLES = 4;
   // This tail outlasts the slowest calc, so it covers any late or extra transaction.
   localparam int unsigned DRAIN_CYCLES  = 100;
   localparam int unsigned HOLD_CYCLES   = 400;

   typedef struct packed {
      pwsm_pkg::cmd_type cmd;
      logic [31:0]       period;
   } meter_cmd_type;

   typedef struct packed {
      logic [15:0]        speed;
      logic signed [31:0] period_change;
      logic [31:0]        total_pulses;
      logic [9:0]         window_pulses;
      logic [31:0]        window_time;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   pwsm_req_if req_if ();
   pwsm_rsp_if rsp_if ();
   pwsm_csr_if csr_if ();

   pulse_window_speed_meter i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // All block inputs come from these registers, so they are known from time zero.
   logic                  req_valid_q  = 1'b0;
   pwsm_pkg::cmd_type     req_cmd_q    = pwsm_pkg::CMD_PULSE;
   logic [31:0]           req_period_q = '0;
   logic                  rsp_ready_q  = 1'b0;
   logic                  csr_valid_q  = 1'b0;
   pwsm_pkg::csr_idx_type csr_index_q  = pwsm_pkg::CSR_PULSE_LIMIT;
   logic [31:0]           csr_data_q   = '0;

   assign req_if.valid  = req_valid_q;
   assign req_if.cmd    = req_cmd_q;
   assign req_if.period = req_period_q;
   assign rsp_if.ready  = rsp_ready_q;
   assign csr_if.valid  = csr_valid_q;
   assign csr_if.index  = csr_index_q;
   assign csr_if.data   = csr_data_q;

   // Stimulus waiting for the driver, and readings predicted for accepted commands.
   meter_cmd_type pending_commands[$];
   reading_type   predicted_readings[$];
   meter_cmd_type next_command;
   reading_type   oldest_reading;

   int unsigned idle_pct = 30;
   logic        hold_trigger = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned fail_count = 0;
   int unsigned commands_queued = 0;
   int unsigned readings_checked = 0;
   int unsigned phases_run = 0;
   int unsigned calc_count = 0;
   int unsigned saturated_count = 0;
   int unsigned stale_count = 0;
   int unsigned change_count = 0;

   // Predictor copy of the configuration registers.
   logic [9:0]  cfg_pulse_limit;
   logic [31:0] cfg_time_limit;
   logic [15:0] cfg_stale_ticks;
   logic [19:0] cfg_distance;

   // Predictor copy of the meter state.
   logic [31:0] acc_time;
   logic [9:0]  acc_pulses;
   logic [31:0] seen_pulses;
   logic [9:0]  win_pulses;
   logic [31:0] win_time;
   logic        win_fresh;
   logic [31:0] tick_count;
   logic [31:0] stamp_tick;
   logic [31:0] last_mean;
   logic [15:0] speed_q;
   logic [31:0] change_q;
   logic [9:0]  used_pulses;
   logic [31:0] used_time;

   function automatic void clear_meter();
      cfg_pulse_limit = pwsm_pkg::PULSE_LIMIT_RST;
      cfg_time_limit  = pwsm_pkg::TIME_LIMIT_RST;
      cfg_stale_ticks = pwsm_pkg::STALE_TICKS_RST;
      cfg_distance    = pwsm_pkg::DISTANCE_FACTOR_RST;
      acc_time    = '0;
      acc_pulses  = '0;
      seen_pulses = '0;
      win_pulses  = '0;
      win_time    = '0;
      win_fresh   = 1'b0;
      tick_count  = '0;
      stamp_tick  = '0;
      last_mean   = '0;
      speed_q     = '0;
      change_q    = '0;
      used_pulses = '0;
      used_time   = '0;
   endfunction

   // Applies one command to the predicted state and returns the reading it must produce.
   function automatic reading_type advance_meter(input pwsm_pkg::cmd_type cmd,
                                                 input logic [31:0] period);
      logic [9:0]  np;
      logic [31:0] tm;
      logic [31:0] age;
      logic [63:0] product;
      logic [31:0] scaled;
      logic [31:0] quot;
      logic [31:0] remd;
      logic [31:0] mean;
      reading_type reading;
      case (cmd)
         pwsm_pkg::CMD_PULSE: begin
            acc_time    = acc_time + period;
            acc_pulses  = acc_pulses + 10'd1;
            seen_pulses = seen_pulses + 32'd1;
            // The pulse count may wrap to zero, which closes the window when the limit is zero.
            if (acc_pulses == cfg_pulse_limit || acc_time > cfg_time_limit) begin
               win_time   = acc_time;
               win_pulses = acc_pulses;
               acc_time   = '0;
               acc_pulses = '0;
               win_fresh  = 1'b1;
            end
         end
         pwsm_pkg::CMD_TICK: begin
            tick_count = tick_count + 32'd1;
         end
         pwsm_pkg::CMD_CALC: begin
            np = win_pulses;
            tm = win_time;
            if (win_fresh) begin
               win_fresh  = 1'b0;
               stamp_tick = tick_count;
            end
            age = tick_count - stamp_tick;
            if (age > {16'd0, cfg_stale_ticks}) begin
               np = '0;
               tm = '0;
               stale_count++;
            end
            used_pulses = np;
            used_time   = tm;
            if (tm > pwsm_pkg::MIN_TIME) begin
               product = {54'd0, np} * {44'd0, cfg_distance};
               scaled  = product[31:0];
               quot    = scaled / tm;
               remd    = scaled % tm;
               if ({remd, 1'b0} >= {1'b0, tm}) begin
                  quot = quot + 32'd1;
               end
               if (quot > {16'd0, pwsm_pkg::SPEED_MAX}) begin
                  speed_q = pwsm_pkg::SPEED_MAX;
                  saturated_count++;
               end else begin
                  speed_q = quot[15:0];
               end
               if (np > pwsm_pkg::MIN_PULSES) begin
                  mean = tm / {22'd0, np};
                  if (last_mean != '0) begin
                     change_q = mean - last_mean;
                     change_count++;
                  end
                  last_mean = mean;
               end
            end else begin
               speed_q = '0;
            end
            calc_count++;
         end
         default: begin
         end
      endcase
      reading.speed         = speed_q;
      reading.period_change = change_q;
      reading.total_pulses  = seen_pulses;
      reading.window_pulses = used_pulses;
      reading.window_time   = used_time;
      return reading;
   endfunction

   // Request driver: the predictor runs on the exact transaction the block accepts.
   always @(posedge clock) begin
      if (reset) begin
         req_valid_q <= 1'b0;
      end else begin
         if (req_valid_q && req_if.ready) begin
            predicted_readings.push_back(advance_meter(req_cmd_q, req_period_q));
         end
         if (!req_valid_q || req_if.ready) begin
            if (pending_commands.size() != 0 && $urandom_range(99) >= idle_pct) begin
               next_command = pending_commands.pop_front();
               req_valid_q  <= 1'b1;
               req_cmd_q    <= next_command.cmd;
               req_period_q <= next_command.period;
            end else begin
               req_valid_q <= 1'b0;
            end
         end
      end
   end

   // The long receiver hold-off is counted here so the monitor only needs to look at it.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_trigger && hold_left == 0) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, label, want, got);
         fail_count++;
      end
   endtask

   // Response monitor: every accepted reading is matched against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else begin
         if (rsp_ready_q && rsp_if.valid) begin
            if (predicted_readings.size() == 0) begin
               $display("%0t: reading with nothing expected, expected none, actual speed %0d",
                        $time, rsp_if.speed);
               fail_count++;
            end else begin
               oldest_reading = predicted_readings.pop_front();
               compare_field("speed", {16'd0, oldest_reading.speed}, {16'd0, rsp_if.speed});
               compare_field("period_change", oldest_reading.period_change,
                             rsp_if.period_change);
               compare_field("total_pulses", oldest_reading.total_pulses, rsp_if.total_pulses);
               compare_field("window_pulses", {22'd0, oldest_reading.window_pulses},
                             {22'd0, rsp_if.window_pulses});
               compare_field("window_time", oldest_reading.window_time, rsp_if.window_time);
               readings_checked++;
            end
         end
         rsp_ready_q <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: run stopped after %0d cycles with %0d readings outstanding", $time,
                  cycle_count, predicted_readings.size());
         $display("pulse_window_speed_meter verification failed");
         $finish;
      end
   end

   function automatic void push_command(input pwsm_pkg::cmd_type cmd, input logic [31:0] period);
      meter_cmd_type entry;
      entry.cmd    = cmd;
      entry.period = period;
      pending_commands.push_back(entry);
      commands_queued++;
   endfunction

   // Periods are drawn from classes that make windows close on count, on time, or both.
   function automatic logic [31:0] pick_period(input int unsigned kind, input int unsigned n);
      case (kind)
         0:       return $urandom_range(3);
         1:       return $urandom_range(65535, 1);
         2:       return $urandom;
         default: return cfg_time_limit / n + $urandom_range(7);
      endcase
   endfunction

   // One measurement window: a run of pulses with ticks mixed in, then one or two calcs.
   function automatic void queue_window();
      int unsigned lim;
      int unsigned n;
      int unsigned kind;
      lim  = (cfg_pulse_limit == 0 || cfg_pulse_limit > 40) ? 40 : cfg_pulse_limit;
      n    = $urandom_range(lim + 2, 1);
      kind = $urandom_range(3);
      for (int unsigned i = 0; i < n; i++) begin
         push_command(pwsm_pkg::CMD_PULSE, pick_period(kind, n));
         if ($urandom_range(99) < 15) begin
            push_command(pwsm_pkg::CMD_TICK, $urandom);
         end
      end
      repeat ($urandom_range(6)) push_command(pwsm_pkg::CMD_TICK, $urandom);
      push_command(pwsm_pkg::CMD_CALC, $urandom);
      // A second calc re-reads the same window, which may have gone stale meanwhile.
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(8)) push_command(pwsm_pkg::CMD_TICK, $urandom);
         push_command(pwsm_pkg::CMD_CALC, $urandom);
      end
   endfunction

   // Waits until every queued command has been sent and every reading has come back.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_commands.size() != 0 || req_valid_q || predicted_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input pwsm_pkg::csr_idx_type index, input logic [31:0] value);
      @(posedge clock);
      csr_valid_q <= 1'b1;
      csr_index_q <= index;
      csr_data_q  <= value;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_valid_q <= 1'b0;
      case (index)
         pwsm_pkg::CSR_PULSE_LIMIT:     cfg_pulse_limit = value[9:0];
         pwsm_pkg::CSR_TIME_LIMIT:      cfg_time_limit  = value;
         pwsm_pkg::CSR_STALE_TICKS:     cfg_stale_ticks = value[15:0];
         pwsm_pkg::CSR_DISTANCE_FACTOR: cfg_distance    = value[19:0];
         default: begin
         end
      endcase
   endtask

   task automatic configure(input logic [31:0] pulse_limit, input logic [31:0] time_limit,
                            input logic [31:0] stale_ticks, input logic [31:0] distance);
      write_reg(pwsm_pkg::CSR_PULSE_LIMIT, pulse_limit);
      write_reg(pwsm_pkg::CSR_TIME_LIMIT, time_limit);
      write_reg(pwsm_pkg::CSR_STALE_TICKS, stale_ticks);
      write_reg(pwsm_pkg::CSR_DISTANCE_FACTOR, distance);
      phases_run++;
   endtask

   // Mostly well-formed windows, with some loose commands of any code as noise.
   task automatic queue_random(input int unsigned budget);
      int unsigned start;
      start = commands_queued;
      while (commands_queued - start < budget) begin
         if ($urandom_range(99) < 80) begin
            queue_window();
         end else begin
            push_command(pwsm_pkg::cmd_type'($urandom_range(3)), $urandom);
         end
      end
   endtask

   initial begin
      logic [31:0] pl;
      logic [31:0] tl;
      logic [31:0] st;
      logic [31:0] df;
      clear_meter();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset configuration: an ignored command, a calc with no
      // window, and two pulses whose time sum jumps past the time limit at the top of range.
      push_command(CMD_UNKNOWN, 32'hFFFF_FFFF);
      push_command(pwsm_pkg::CMD_CALC, '0);
      push_command(pwsm_pkg::CMD_TICK, '0);
      push_command(pwsm_pkg::CMD_PULSE, '0);
      push_command(pwsm_pkg::CMD_PULSE, 32'hFFFF_FFFF);
      push_command(pwsm_pkg::CMD_CALC, '0);
      push_command(CMD_UNKNOWN, '0);
      wait_drained();

      // Windows close on a count of six. The first window lands exactly on a half in the
      // speed division and sets the first mean; the second updates the period change; the
      // final calc comes after enough ticks for the window to read as stale.
      configure(32'd6, 32'hFFFF_FFFF, 32'd3, 32'd1000000);
      repeat (6) push_command(pwsm_pkg::CMD_PULSE, 32'd640);
      push_command(pwsm_pkg::CMD_CALC, '0);
      repeat (6) push_command(pwsm_pkg::CMD_PULSE, 32'd100);
      push_command(pwsm_pkg::CMD_CALC, '0);
      repeat (4) push_command(pwsm_pkg::CMD_TICK, '0);
      push_command(pwsm_pkg::CMD_CALC, '0);
      wait_drained();

      // Lowest settings: every pulse closes a window and small periods give short times.
      configure(32'd1, 32'd1, 32'd0, 32'd1);
      queue_random(150);
      wait_drained();

      // Largest pulse limit, so windows close on time; the stale limit is never reached.
      configure(32'd1023, 32'd50000, 32'd65535, 32'd1000000);
      queue_random(150);
      wait_drained();

      // A zero pulse limit with no time limit: the window closes only when the pulse
      // count wraps after 1024 pulses. Calcs along the way must see no fresh window.
      configure(32'd0, 32'hFFFF_FFFF, 32'd65535, 32'd1000000);
      for (int unsigned i = 0; i < 1030; i++) begin
         push_command(pwsm_pkg::CMD_PULSE, $urandom_range(3));
         if (i % 256 == 255 || i == 1025) begin
            push_command(pwsm_pkg::CMD_CALC, $urandom);
         end
      end
      wait_drained();

      // Zero pulse limit again, now with the time limit closing the windows.
      configure(32'd0, 32'd20000, 32'd5, $urandom_range(1000000, 1));
      queue_random(150);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         pl = $urandom_range(40, 2);
         case ($urandom_range(2))
            0:       tl = $urandom_range(5000, 3);
            1:       tl = $urandom_range(2000000, 5000);
            default: tl = $urandom;
         endcase
         st = ($urandom_range(3) == 0) ? 32'd65535 : $urandom_range(12);
         df = $urandom_range(1000000, 1);
         // One phase runs without any idling on either side.
         idle_pct = (p == 2) ? 0 : 30;
         configure(pl, tl, st, df);
         queue_random(130);
         if (p == 1) begin
            // The receiver stalls for a long stretch while commands keep coming, which
            // backs the block up until it stops accepting requests.
            @(posedge clock);
            hold_trigger <= 1'b1;
            @(posedge clock);
            hold_trigger <= 1'b0;
         end
         wait_drained();
      end
      idle_pct = 30;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_readings.size() != 0) begin
         $display("%0t: %0d expected readings never arrived", $time, predicted_readings.size());
         fail_count++;
      end
      $display("Checked %0d readings from %0d commands over %0d register settings.",
               readings_checked, commands_queued, phases_run);
      $display("Calcs: %0d, saturated: %0d, stale windows: %0d, period change updates: %0d.",
               calc_count, saturated_count, stale_count, change_count);
      if (fail_count == 0) begin
         $display("pulse_window_speed_meter verification clean");
      end else begin
         $display("pulse_window_speed_meter verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/pwsm_pkg.sv
hw/rtl/pwsm_req_if.sv
hw/rtl/pwsm_rsp_if.sv
hw/rtl/pwsm_csr_if.sv
hw/rtl/pwsm_datapath.sv
hw/rtl/pwsm_ctrl.sv
hw/rtl/pulse_window_speed_meter.sv
dv/pulse_window_speed_meter_tb.sv
